[design/obb_fas_pkg.sv]
// Shared types, codes and constants for the oriented box face-axis separation block.
// No dependencies; every other design file imports this package.
package obb_fas_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int SLOTS_PER_BOX  = 15;
    localparam int STORE_DEPTH    = 2 * SLOTS_PER_BOX;
    localparam int ADDR_W         = 5;
    localparam int OPND_W         = 33;
    localparam int ACC_W          = 64;
    localparam int CUTOFF_W       = 17;
    localparam int CFG_ADDR_W     = 3;

    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 17'd65470;
    localparam logic [3:0] SLOT_INVALID = 4'd15;

    localparam logic [ADDR_W-1:0] AXIS0_BASE = 5'd3;
    localparam logic [ADDR_W-1:0] AXIS1_BASE = 5'd18;
    localparam logic [ADDR_W-1:0] EXT0_BASE  = 5'd12;
    localparam logic [ADDR_W-1:0] EXT1_BASE  = 5'd27;
    localparam logic [ADDR_W-1:0] CTR1_BASE  = 5'd15;

    localparam logic [1:0] OUT_SEP = 2'd0;
    localparam logic [1:0] OUT_PAR = 2'd1;
    localparam logic [1:0] OUT_UND = 2'd2;

    localparam logic REG_CUTOFF = 1'b0;

    typedef struct packed {
        logic               box_sel;
        logic [3:0]         slot;
        logic signed [31:0] value;
        logic               last;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic [2:0]         axis_index;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
    } out_word_t;

    typedef enum logic [4:0] {
        S_IDLE, S_D0, S_D1, S_D2,
        S_FA, S_FB, S_LB, S_MUL, S_ACC, S_ABS,
        S_X0, S_CMP, S_O0, S_O1, S_O2, S_O3
    } state_t;

    typedef enum logic [2:0] {
        PH_AA, PH_EA, PH_DA, PH_EB, PH_DB
    } phase_t;

endpackage

[design/obb_fas_store.sv]
// Box value store: thirty 32-bit entries, one write port and one registered read port.
// Depends on obb_fas_pkg.
module obb_fas_store (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [obb_fas_pkg::ADDR_W-1:0] wr_addr,
    input  logic [31:0]                   wr_data,
    input  logic [obb_fas_pkg::ADDR_W-1:0] rd_addr,
    output logic [31:0]                   rd_data
);
    import obb_fas_pkg::*;

    logic [31:0] mem [STORE_DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/obb_fas_mul.sv]
// Shared fixed-point multiplier: registered 33x33 product, floor-shifted by the fraction bits.
// Depends on obb_fas_pkg.
module obb_fas_mul #(
    parameter int FRAC_BITS = obb_fas_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic signed [obb_fas_pkg::OPND_W-1:0] opa,
    input  logic signed [obb_fas_pkg::OPND_W-1:0] opb,
    output logic signed [obb_fas_pkg::ACC_W-1:0]  term
);
    import obb_fas_pkg::*;

    logic signed [2*OPND_W-1:0] prod_reg;
    logic signed [2*OPND_W-1:0] shifted;

    always_ff @(posedge aclk) begin
        prod_reg <= opa * opb;
    end

    assign shifted = prod_reg >>> FRAC_BITS;
    assign term    = shifted[ACC_W-1:0];

endmodule

[design/obb_fas_top_ctrl.sv]
// Sequencer and datapath registers for the face-axis test, driving the shared multiplier.
// Depends on obb_fas_pkg, obb_fas_store and obb_fas_mul.
module obb_fas_top_ctrl #(
    parameter int FRAC_BITS = obb_fas_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  obb_fas_pkg::in_word_t                s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output obb_fas_pkg::out_word_t               m_data,
    input  logic [obb_fas_pkg::CUTOFF_W-1:0]     cutoff
);
    import obb_fas_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [1:0] o_reg, o_next, n_reg, n_next, k_reg, k_next;
    logic sec_reg, sec_next, par_reg, par_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next, rl_reg, rl_next;
    logic signed [31:0] dist_reg [3];
    logic signed [31:0] ctr_reg;
    logic [31:0] a_reg;
    logic [31:0] absdot_reg [9];
    logic signed [OPND_W-1:0] opa_reg, opb_reg;
    logic m_valid_reg;
    out_word_t out_reg;

    logic [ADDR_W-1:0] rd_addr, addr_a, addr_b, axis_base;
    logic [31:0] rd_data;
    logic signed [ACC_W-1:0] term;
    logic signed [OPND_W-1:0] rd_sext;
    logic signed [32:0] dsub;
    logic signed [31:0] dsat, dot_sat;
    logic [31:0] dot_abs;
    logic [3:0] ad_idx_rd, ad_idx_wr;
    logic signed [ACC_W-1:0] r_abs, lim, ext_sext;
    logic in_acc, sep;

    assign in_acc  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE) && !(m_valid_reg && s_data.last);

    obb_fas_store u_store (
        .aclk    (aclk),
        .wr_en   (in_acc && (s_data.slot != SLOT_INVALID)),
        .wr_addr (s_data.box_sel ? (CTR1_BASE + {1'b0, s_data.slot}) : {1'b0, s_data.slot}),
        .wr_data (s_data.value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    obb_fas_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk (aclk),
        .opa  (opa_reg),
        .opb  (opb_reg),
        .term (term)
    );

    assign rd_sext   = {rd_data[31], rd_data};
    assign ad_idx_rd = 4'(3 * n_reg + o_reg);
    assign ad_idx_wr = 4'(3 * o_reg + n_reg);
    assign dsub      = {ctr_reg[31], ctr_reg} - {rd_data[31], rd_data};
    assign dsat      = (dsub > 33'sd2147483647) ? 32'sh7FFFFFFF :
                       (dsub < -33'sd2147483648) ? 32'sh80000000 : dsub[31:0];
    assign dot_sat   = (acc_reg > 64'sd2147483647) ? 32'sh7FFFFFFF :
                       (acc_reg < -64'sd2147483648) ? 32'sh80000000 : acc_reg[31:0];
    assign dot_abs   = dot_sat[31] ? (~dot_sat + 32'd1) : dot_sat;
    assign r_abs     = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign ext_sext  = {{(ACC_W-32){rd_data[31]}}, rd_data};
    assign lim       = ext_sext + rl_reg;
    assign sep       = r_abs > lim;
    assign axis_base = sec_reg ? (AXIS1_BASE + 5'(3 * o_reg)) : (AXIS0_BASE + 5'(3 * o_reg));

    always_comb begin
        unique case (phase_reg)
            PH_AA:   addr_a = AXIS0_BASE + 5'(3 * o_reg) + {3'b0, k_reg};
            PH_EA:   addr_a = EXT1_BASE + {3'b0, n_reg};
            PH_EB:   addr_a = EXT0_BASE + {3'b0, n_reg};
            default: addr_a = '0;
        endcase
        unique case (phase_reg)
            PH_AA:   addr_b = AXIS1_BASE + 5'(3 * n_reg) + {3'b0, k_reg};
            PH_DA:   addr_b = AXIS0_BASE + 5'(3 * o_reg) + {3'b0, k_reg};
            PH_DB:   addr_b = AXIS1_BASE + 5'(3 * o_reg) + {3'b0, k_reg};
            default: addr_b = '0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        o_next     = o_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        sec_next   = sec_reg;
        par_next   = par_reg;
        acc_next   = acc_reg;
        rl_next    = rl_reg;
        rd_addr    = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc && s_data.last) begin
                    state_next = S_D0;
                    k_next     = '0;
                    par_next   = 1'b0;
                end
            end
            S_D0: begin
                rd_addr    = CTR1_BASE + {3'b0, k_reg};
                state_next = S_D1;
            end
            S_D1: begin
                rd_addr    = {3'b0, k_reg};
                state_next = S_D2;
            end
            S_D2: begin
                if (k_reg == 2'd2) begin
                    state_next = S_FA;
                    phase_next = PH_AA;
                    o_next     = '0;
                    n_next     = '0;
                    k_next     = '0;
                    sec_next   = 1'b0;
                    acc_next   = '0;
                    rl_next    = '0;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_D0;
                end
            end
            S_FA: begin
                rd_addr    = addr_a;
                state_next = S_FB;
            end
            S_FB: begin
                rd_addr    = addr_b;
                state_next = S_LB;
            end
            S_LB:  state_next = S_MUL;
            S_MUL: state_next = S_ACC;
            S_ACC: begin
                state_next = S_FA;
                unique case (phase_reg)
                    PH_AA: begin
                        acc_next = acc_reg + term;
                        if (k_reg == 2'd2) begin
                            state_next = S_ABS;
                        end else begin
                            k_next = k_reg + 2'd1;
                        end
                    end
                    PH_EA: begin
                        rl_next  = rl_reg + term;
                        acc_next = '0;
                        k_next   = '0;
                        if (n_reg == 2'd2) begin
                            phase_next = PH_DA;
                        end else begin
                            n_next     = n_reg + 2'd1;
                            phase_next = PH_AA;
                        end
                    end
                    PH_EB: begin
                        rl_next = rl_reg + term;
                        if (n_reg == 2'd2) begin
                            phase_next = PH_DB;
                            acc_next   = '0;
                            k_next     = '0;
                        end else begin
                            n_next = n_reg + 2'd1;
                        end
                    end
                    default: begin
                        acc_next = acc_reg + term;
                        if (k_reg == 2'd2) begin
                            state_next = S_X0;
                        end else begin
                            k_next = k_reg + 2'd1;
                        end
                    end
                endcase
            end
            S_ABS: begin
                if (dot_abs > {15'b0, cutoff}) begin
                    par_next = 1'b1;
                end
                phase_next = PH_EA;
                state_next = S_FA;
            end
            S_X0: begin
                rd_addr    = sec_reg ? (EXT1_BASE + {3'b0, o_reg})
                                     : (EXT0_BASE + {3'b0, o_reg});
                state_next = S_CMP;
            end
            S_CMP: begin
                k_next   = '0;
                n_next   = '0;
                acc_next = '0;
                rl_next  = '0;
                if (sep) begin
                    state_next = S_O0;
                end else if (o_reg == 2'd2) begin
                    if (!sec_reg) begin
                        sec_next   = 1'b1;
                        o_next     = '0;
                        phase_next = PH_EB;
                        state_next = S_FA;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    o_next     = o_reg + 2'd1;
                    phase_next = sec_reg ? PH_EB : PH_AA;
                    state_next = S_FA;
                end
            end
            S_O0: begin
                rd_addr    = axis_base;
                state_next = S_O1;
            end
            S_O1: begin
                rd_addr    = axis_base + 5'd1;
                state_next = S_O2;
            end
            S_O2: begin
                rd_addr    = axis_base + 5'd2;
                state_next = S_O3;
            end
            S_O3:    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_AA;
            o_reg       <= '0;
            n_reg       <= '0;
            k_reg       <= '0;
            sec_reg     <= 1'b0;
            par_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            o_reg     <= o_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            sec_reg   <= sec_next;
            par_reg   <= par_next;
            if ((state_reg == S_O3) ||
                    ((state_reg == S_CMP) && !sep && (o_reg == 2'd2) && sec_reg)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        rl_reg  <= rl_next;
        if (state_reg == S_D1) begin
            ctr_reg <= rd_data;
        end
        if (state_reg == S_D2) begin
            dist_reg[k_reg] <= dsat;
        end
        if (state_reg == S_ABS) begin
            a_reg                  <= dot_abs;
            absdot_reg[ad_idx_wr]  <= dot_abs;
        end
        if (state_reg == S_FB) begin
            opa_reg <= ((phase_reg == PH_DA) || (phase_reg == PH_DB))
                       ? {dist_reg[k_reg][31], dist_reg[k_reg]} : rd_sext;
        end
        if (state_reg == S_LB) begin
            unique case (phase_reg)
                PH_EA:   opb_reg <= {1'b0, a_reg};
                PH_EB:   opb_reg <= {1'b0, absdot_reg[ad_idx_rd]};
                default: opb_reg <= rd_sext;
            endcase
        end
        if (state_reg == S_CMP) begin
            out_reg.outcome    <= sep ? OUT_SEP : (par_reg ? OUT_PAR : OUT_UND);
            out_reg.axis_index <= sep ? (sec_reg ? (3'd3 + {1'b0, o_reg}) : {1'b0, o_reg})
                                      : 3'd0;
            out_reg.axis_x     <= '0;
            out_reg.axis_y     <= '0;
            out_reg.axis_z     <= '0;
        end
        if (state_reg == S_O1) out_reg.axis_x <= rd_data;
        if (state_reg == S_O2) out_reg.axis_y <= rd_data;
        if (state_reg == S_O3) out_reg.axis_z <= rd_data;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == S_IDLE))
        else $error("Input taken while a test is running.");

    a_last_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last) |=> (state_reg == S_D0))
        else $error("A last word did not start the test.");

    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (out_reg.outcome == OUT_SEP)) |-> (out_reg.axis_index <= 3'd5))
        else $error("Separating axis index out of range.");

    a_no_sep_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (out_reg.outcome != OUT_SEP)) |->
        ((out_reg.axis_index == 3'd0) && (out_reg.axis_x == 32'sd0)))
        else $error("Non-separated result carries an axis.");

endmodule

[design/obb_face_axis_separation.sv]
// Oriented box face-axis separation test. A word with last low loads one scalar. A word
// with last high loads its scalar and starts the test; the block then holds s_ready low
// until the test ends, as the single shared multiplier forms one product at a time and the
// worst case of no separating face axis needs 63 products. A word with last high also
// waits while the previous result has not been taken.
// Depends on obb_fas_pkg and obb_fas_top_ctrl.
module obb_face_axis_separation #(
    parameter int FRAC_BITS = obb_fas_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  obb_fas_pkg::in_word_t                s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output obb_fas_pkg::out_word_t               m_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [obb_fas_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import obb_fas_pkg::*;

    logic [CUTOFF_W-1:0] cutoff_reg;
    logic                reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_CUTOFF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= CUTOFF_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            cutoff_reg <= pwdata[CUTOFF_W-1:0];
        end
    end

    assign prdata = reg_hit ? {{(32-CUTOFF_W){1'b0}}, cutoff_reg} : 32'd0;

    obb_fas_top_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cutoff  (cutoff_reg)
    );

endmodule

[verif/obb_face_axis_separation_check.sv]
// Checker for the oriented box face-axis separation block: watches both word channels,
// predicts each test result from its own copy of the box store, and counts mismatches.
// Depends on obb_fas_pkg.
module obb_face_axis_separation_check (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  obb_fas_pkg::in_word_t  s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  obb_fas_pkg::out_word_t m_data,
    input  logic [16:0]            cutoff,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import obb_fas_pkg::*;

    logic [31:0] boxes [0:29];
    out_word_t   expected_q [$];

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> FRAC_BITS_DEF;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint labs(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint fetch(int b, int s);
        return longint'($signed(boxes[b * SLOTS_PER_BOX + s]));
    endfunction

    function automatic longint dot_axes(int bu, int u, int bv, int v, longint d[3],
                                        bit use_dist);
        longint acc;
        acc = 0;
        for (int c = 0; c < 3; c++)
            acc += qmul(use_dist ? d[c] : fetch(bu, 3 + 3 * u + c), fetch(bv, 3 + 3 * v + c));
        return acc;
    endfunction

    function automatic out_word_t separation_test();
        longint dvec[3];
        longint absdot[9];
        longint r, rl;
        bit par;
        out_word_t w;
        w = '0;
        par = 0;
        for (int c = 0; c < 3; c++) dvec[c] = sat32(fetch(1, c) - fetch(0, c));
        for (int i = 0; i < 3; i++) begin
            rl = 0;
            for (int j = 0; j < 3; j++) begin
                absdot[3 * i + j] = labs(sat32(dot_axes(0, i, 1, j, dvec, 0)));
                if (absdot[3 * i + j] > longint'(cutoff)) par = 1;
                rl += qmul(fetch(1, 12 + j), absdot[3 * i + j]);
            end
            r = labs(dot_axes(0, 0, 0, i, dvec, 1));
            if (r > fetch(0, 12 + i) + rl) begin
                w.outcome = OUT_SEP;
                w.axis_index = i;
                w.axis_x = boxes[3 + 3 * i];
                w.axis_y = boxes[4 + 3 * i];
                w.axis_z = boxes[5 + 3 * i];
                return w;
            end
        end
        for (int j = 0; j < 3; j++) begin
            rl = 0;
            for (int i = 0; i < 3; i++) rl += qmul(fetch(0, 12 + i), absdot[3 * i + j]);
            r = labs(dot_axes(0, 0, 1, j, dvec, 1));
            if (r > rl + fetch(1, 12 + j)) begin
                w.outcome = OUT_SEP;
                w.axis_index = 3 + j;
                w.axis_x = boxes[18 + 3 * j];
                w.axis_y = boxes[19 + 3 * j];
                w.axis_z = boxes[20 + 3 * j];
                return w;
            end
        end
        w.outcome = par ? OUT_PAR : OUT_UND;
        return w;
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected word: expected none, actual %h", $time, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    if (m_data.outcome !== expected_q[0].outcome ||
                        m_data.axis_index !== expected_q[0].axis_index ||
                        m_data.axis_x !== expected_q[0].axis_x ||
                        m_data.axis_y !== expected_q[0].axis_y ||
                        m_data.axis_z !== expected_q[0].axis_z) begin
                        $display("%0t mismatch: expected %h, actual %h",
                                 $time, expected_q[0], m_data);
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_q.pop_front());
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.slot != SLOT_INVALID)
                    boxes[s_data.box_sel * SLOTS_PER_BOX + s_data.slot] = s_data.value;
                if (s_data.last) expected_q.push_back(separation_test());
            end
        end
    end
endmodule

[verif/obb_face_axis_separation_test.sv]
// Top of the testbench for the oriented box face-axis separation block: drives box loads,
// cutoff writes and result stalls, and gives the verdict from the checker's count.
// Depends on obb_fas_pkg, obb_face_axis_separation and obb_face_axis_separation_check.
module obb_face_axis_separation_test;
    timeunit 1ns;
    timeprecision 1ps;
    import obb_fas_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    out_word_t m_data;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic [16:0] cutoff = CUTOFF_RESET;
    int fail_count, pending, idle_cycles;
    int m_wait;

    always #10 aclk = ~aclk;

    obb_face_axis_separation DUT (.*);

    obb_face_axis_separation_check checker_i (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cutoff, .fail_count, .pending
    );

    task automatic write_cutoff(logic [31:0] v);
        @(posedge aclk);
        psel <= 1; pwrite <= 1; paddr <= {REG_CUTOFF, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        cutoff <= v[16:0];
    endtask

    task automatic send_word(logic b, logic [3:0] s, logic [31:0] v, logic l, int gap);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= '{box_sel: b, slot: s, value: v, last: l};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_q(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 131072) - 65536;
            2: return $urandom_range(0, 8388608) - 4194304;
            default: return $urandom_range(0, 1) ? 32'h00010000 : 32'h0;
        endcase
    endfunction

    task automatic load_boxes(int mode, bit rgap);
        for (int b = 0; b < 2; b++)
            for (int s = 0; s < SLOTS_PER_BOX; s++)
                send_word(b, s, (s >= 3 && s < 12) ? rand_q(mode == 3 ? 3 : 1) : rand_q(mode),
                          (b == 1 && s == 14), rgap ? $urandom_range(0, 16) : 0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
            m_wait  <= $urandom_range(0, 16);
        end else if (m_valid && m_ready) begin
            m_ready <= 0;
            m_wait  <= $urandom_range(0, 16);
        end else if (m_valid && !m_ready) begin
            if (m_wait == 0) m_ready <= 1;
            else m_wait <= m_wait - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAIL obb_face_axis_separation");
            $finish;
        end
    end

    initial begin
        logic [31:0] cuts [4];
        cuts = '{32'd0, 32'd65536, 32'h1FFFF, 32'd65470};
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        write_cutoff(32'd65536);
        load_boxes(0, 0);
        load_boxes(3, 0);
        send_word(0, 4'd0, 32'h7FFFFFFF, 0, 0);
        send_word(1, 4'd0, 32'h80000000, 1, 0);
        send_word(0, SLOT_INVALID, 32'hFFFFFFFF, 1, 0);
        send_word(1, 4'd12, 32'hFFFF0000, 1, 0);
        drain();
        for (int p = 0; p < 4; p++) begin
            write_cutoff(p == 1 ? $urandom_range(0, 131071) : cuts[p]);
            for (int k = 0; k < 13; k++) begin
                load_boxes($urandom_range(0, 3), $urandom_range(0, 1));
                for (int n = $urandom_range(0, 3); n > 0; n--)
                    send_word($urandom_range(0, 1), $urandom_range(0, 15), rand_q(0),
                              $urandom_range(0, 1), $urandom_range(0, 16));
            end
            drain();
        end
        drain();
        if (fail_count == 0) $display("PASS obb_face_axis_separation");
        else $display("FAIL obb_face_axis_separation");
        $finish;
    end
endmodule

[files.f]
design/obb_fas_pkg.sv
design/obb_fas_store.sv
design/obb_fas_mul.sv
design/obb_fas_top_ctrl.sv
design/obb_face_axis_separation.sv
verif/obb_face_axis_separation_check.sv
verif/obb_face_axis_separation_test.sv
